// File: hw/rtl/per_pixel_scalar_kalman_macros.svh
// Assertion macros used by the checker file.
`ifndef PER_PIXEL_SCALAR_KALMAN_MACROS_SVH
`define PER_PIXEL_SCALAR_KALMAN_MACROS_SVH

// Check out of reset.
`define PPSK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check at every edge, reset included.
`define PPSK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/ppsk_pkg.sv
// Package: constants, codes and types of the per-pixel Kalman denoiser.
package ppsk_pkg;

    localparam int MAX_ELEMENTS_DEF = 262144;
    localparam int CHANNELS_DEF     = 4;

    localparam int PC_W   = 17;
    localparam int COV_W  = 32;
    localparam int EST_W  = 16;
    localparam int GAIN_W = 17;
    localparam int SUM_W  = 33;

    localparam logic [PC_W-1:0]  PIXEL_COUNT_RST = 17'd65536;
    localparam logic [COV_W-1:0] NOISE_RST       = 32'd65536;
    localparam logic [GAIN_W-1:0] GAIN_ONE       = 17'd65536;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        REG_PIXEL_COUNT        = 2'd0,
        REG_PROCESS_NOISE      = 2'd1,
        REG_MEASUREMENT_NOISE  = 2'd2,
        REG_INITIAL_COVARIANCE = 2'd3
    } ppsk_reg_t;

    typedef struct packed {
        logic [COV_W-1:0] pred;
        logic [EST_W-1:0] est;
        logic [7:0]       z;
        logic             last;
    } ppsk_tag_t;

endpackage

// File: hw/rtl/ppsk_ram.sv
// Generic simple dual-port RAM with registered read.
module ppsk_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/ppsk_div.sv
// Pipelined restoring divider forming the Kalman gain, one quotient bit per stage.
module ppsk_div #(
    parameter int IDX_W = 18
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [ppsk_pkg::SUM_W-1:0] in_sum,
    input  ppsk_pkg::ppsk_tag_t       in_tag,
    input  logic [IDX_W-1:0]          in_idx,
    input  logic [IDX_W-1:0]          probe_idx,
    output logic                      probe_hit,
    output logic                      busy,
    output logic                      out_valid,
    output logic [ppsk_pkg::GAIN_W-1:0] out_gain,
    output ppsk_pkg::ppsk_tag_t       out_tag,
    output logic [IDX_W-1:0]          out_idx
);
    import ppsk_pkg::*;

    localparam int NS  = GAIN_W;
    localparam int REM_W = SUM_W + 1;

    logic                valid_reg [NS];
    logic [REM_W-1:0]    rem_reg   [NS];
    logic [GAIN_W-1:0]   quo_reg   [NS];
    logic [SUM_W-1:0]    sum_reg   [NS];
    ppsk_tag_t           tag_reg   [NS];
    logic [IDX_W-1:0]    idx_reg   [NS];
    logic [NS-1:0]       hit_vec;
    logic [NS-1:0]       busy_vec;

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_stage
            logic [REM_W-1:0]  rem_in;
            logic [GAIN_W-1:0] quo_in;
            logic [SUM_W-1:0]  sum_in;
            logic              vld_in;
            ppsk_tag_t         tag_in;
            logic [IDX_W-1:0]  idx_in;
            logic              ge;
            logic [REM_W-1:0]  diff;

            if (k == 0)
            begin : g_first
                assign rem_in = {{(REM_W-COV_W){1'b0}}, in_tag.pred};
                assign quo_in = '0;
                assign sum_in = in_sum;
                assign vld_in = in_valid;
                assign tag_in = in_tag;
                assign idx_in = in_idx;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign sum_in = sum_reg[k-1];
                assign vld_in = valid_reg[k-1];
                assign tag_in = tag_reg[k-1];
                assign idx_in = idx_reg[k-1];
            end

            assign ge   = rem_in >= {1'b0, sum_in};
            assign diff = ge ? rem_in - {1'b0, sum_in} : rem_in;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= {diff[REM_W-2:0], 1'b0};
                    quo_reg[k] <= {quo_in[GAIN_W-2:0], ge};
                    sum_reg[k] <= sum_in;
                    tag_reg[k] <= tag_in;
                    idx_reg[k] <= idx_in;
                end
            end

            assign hit_vec[k]  = valid_reg[k] && (idx_reg[k] == probe_idx);
            assign busy_vec[k] = valid_reg[k];
        end
    endgenerate

    assign probe_hit = |hit_vec;
    assign busy      = |busy_vec;
    assign out_valid = valid_reg[NS-1];
    assign out_gain  = (sum_reg[NS-1] == '0) ? '0 : quo_reg[NS-1];
    assign out_tag   = tag_reg[NS-1];
    assign out_idx   = idx_reg[NS-1];

endmodule

// File: hw/rtl/per_pixel_scalar_kalman.sv
// Top level: per-element scalar Kalman temporal denoiser.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata = sample, s_tuser = operation
//  m_      | out | m_tvalid/m_tready | m_tdata = filtered, m_tlast = frame_last
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request per cycle while successive requests hit distinct elements.
// Pipeline stages: RAM read, predict, 17 divider stages, multiply, write back.
// A request to an element still in flight waits for its write back, and a
// clear waits until the pipeline drains. Reset clears no memory: a fill count
// marks written entries. The whole pipeline holds while the output register
// is full and not taken.
module per_pixel_scalar_kalman #(
    parameter int MAX_ELEMENTS = ppsk_pkg::MAX_ELEMENTS_DEF,
    parameter int CHANNELS     = ppsk_pkg::CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] filtered
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ppsk_pkg::*;

    localparam int POS_W  = $clog2(MAX_ELEMENTS);
    localparam int FILL_W = POS_W + 1;
    localparam int LIM_W  = (PC_W + 3 > FILL_W) ? PC_W + 3 : FILL_W;
    localparam int MEM_W  = COV_W + EST_W;

    logic [PC_W-1:0]  pixel_count_reg;
    logic [COV_W-1:0] process_noise_reg;
    logic [COV_W-1:0] measurement_noise_reg;
    logic [COV_W-1:0] initial_covariance_reg;
    logic [COV_W-1:0] clear_cov_reg;
    logic [POS_W-1:0] pos_reg;
    logic [FILL_W-1:0] fill_reg;

    logic adv;
    logic accept;
    logic take_filter;
    logic take_clear;
    logic hazard;
    logic busy;

    // Frame length and position
    logic [PC_W-1:0]  pc_eff;
    logic [LIM_W-1:0] frame_n;
    logic [LIM_W-1:0] limit;
    logic             last;
    logic             fresh;

    assign pc_eff  = (pixel_count_reg == '0) ? PC_W'(1) : pixel_count_reg;
    assign frame_n = LIM_W'(pc_eff) * LIM_W'(CHANNELS);
    assign limit   = (frame_n > LIM_W'(MAX_ELEMENTS)) ? LIM_W'(MAX_ELEMENTS) : frame_n;
    assign last    = LIM_W'(pos_reg) >= (limit - LIM_W'(1));
    assign fresh   = FILL_W'(pos_reg) < fill_reg;

    // Read stage
    logic             s1_valid_reg;
    logic             s1_fresh_reg;
    logic             s1_last_reg;
    logic [7:0]       s1_z_reg;
    logic [POS_W-1:0] s1_idx_reg;
    logic [MEM_W-1:0] rd_data;

    // Predict stage
    logic             p_valid_reg;
    logic [SUM_W-1:0] p_sum_reg;
    ppsk_tag_t        p_tag_reg;
    logic [POS_W-1:0] p_idx_reg;
    logic [EST_W-1:0] est_old;
    logic [COV_W-1:0] cov_old;
    logic [COV_W:0]   pred_wide;
    logic [COV_W-1:0] pred_sat;

    // Divider
    logic              d_valid;
    logic [GAIN_W-1:0] d_gain;
    ppsk_tag_t         d_tag;
    logic [POS_W-1:0]  d_idx;
    logic              d_hit;
    logic              d_busy;

    // Multiply stage
    logic              m_valid_reg;
    logic [32:0]       m_a_reg;
    logic [32:0]       m_b_reg;
    logic [48:0]       m_c_reg;
    logic              m_last_reg;
    logic [POS_W-1:0]  m_idx_reg;
    logic [GAIN_W-1:0] inv;
    logic [33:0]       est_sum;
    logic [EST_W-1:0]  est_new;
    logic [COV_W-1:0]  cov_new;
    logic              wr_en;

    // Output register
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    logic              out_last_reg;

    assign adv    = !out_valid_reg || m_tready;
    assign hazard = (s1_valid_reg && s1_idx_reg == pos_reg)
                 || (p_valid_reg && p_idx_reg == pos_reg)
                 || d_hit
                 || (m_valid_reg && m_idx_reg == pos_reg);
    assign busy   = s1_valid_reg || p_valid_reg || d_busy || m_valid_reg;

    assign s_tready    = adv && ((s_tuser == OP_CLEAR) ? !busy : !hazard);
    assign accept      = s_tvalid && s_tready;
    assign take_filter = accept && (s_tuser == OP_FILTER);
    assign take_clear  = accept && (s_tuser == OP_CLEAR);
    assign cfg_ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg        <= PIXEL_COUNT_RST;
            process_noise_reg      <= NOISE_RST;
            measurement_noise_reg  <= NOISE_RST;
            initial_covariance_reg <= NOISE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ppsk_reg_t'(cfg_index))
                REG_PIXEL_COUNT:        pixel_count_reg        <= cfg_data[PC_W-1:0];
                REG_PROCESS_NOISE:      process_noise_reg      <= cfg_data;
                REG_MEASUREMENT_NOISE:  measurement_noise_reg  <= cfg_data;
                REG_INITIAL_COVARIANCE: initial_covariance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fill_reg      <= '0;
            clear_cov_reg <= NOISE_RST;
        end
        else if (take_clear)
        begin
            pos_reg       <= '0;
            fill_reg      <= '0;
            clear_cov_reg <= initial_covariance_reg;
        end
        else if (take_filter)
        begin
            pos_reg <= last ? '0 : pos_reg + POS_W'(1);
            if (!fresh)
            begin
                fill_reg <= FILL_W'(pos_reg) + FILL_W'(1);
            end
        end
    end

    ppsk_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (m_idx_reg),
        .wdata ({cov_new, est_new}),
        .re    (adv),
        .raddr (pos_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= take_filter;
            p_valid_reg  <= s1_valid_reg;
            m_valid_reg  <= d_valid;
        end
    end

    assign est_old   = s1_fresh_reg ? rd_data[EST_W-1:0] : '0;
    assign cov_old   = s1_fresh_reg ? rd_data[MEM_W-1:EST_W] : clear_cov_reg;
    assign pred_wide = {1'b0, cov_old} + {1'b0, process_noise_reg};
    assign pred_sat  = pred_wide[COV_W] ? '1 : pred_wide[COV_W-1:0];

    assign inv = GAIN_ONE - d_gain;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_fresh_reg   <= fresh;
            s1_last_reg    <= last;
            s1_z_reg       <= s_tdata;
            s1_idx_reg     <= pos_reg;
            p_sum_reg      <= {1'b0, pred_sat} + {1'b0, measurement_noise_reg};
            p_tag_reg.pred <= pred_sat;
            p_tag_reg.est  <= est_old;
            p_tag_reg.z    <= s1_z_reg;
            p_tag_reg.last <= s1_last_reg;
            p_idx_reg      <= s1_idx_reg;
            m_a_reg        <= d_tag.est * inv;
            m_b_reg        <= {d_tag.z, 8'h00} * d_gain;
            m_c_reg        <= d_tag.pred * inv;
            m_last_reg     <= d_tag.last;
            m_idx_reg      <= d_idx;
        end
    end

    ppsk_div #(
        .IDX_W (POS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p_valid_reg),
        .in_sum    (p_sum_reg),
        .in_tag    (p_tag_reg),
        .in_idx    (p_idx_reg),
        .probe_idx (pos_reg),
        .probe_hit (d_hit),
        .busy      (d_busy),
        .out_valid (d_valid),
        .out_gain  (d_gain),
        .out_tag   (d_tag),
        .out_idx   (d_idx)
    );

    assign est_sum = {1'b0, m_a_reg} + {1'b0, m_b_reg};
    assign est_new = est_sum[31:16];
    assign cov_new = m_c_reg[47:16];
    assign wr_en   = adv && m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            out_data_reg <= est_new[15:8];
            out_last_reg <= m_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/ppsk_check.sv
// Port checker for the denoiser top level, bound to it.
`include "per_pixel_scalar_kalman_macros.svh"

module ppsk_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [31:0] cfg_data
);
    import ppsk_pkg::*;

    `PPSK_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    `PPSK_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_tvalid, "result shown during reset")
    `PPSK_ASSERT(a_clear_silent, s_tvalid && s_tready && s_tuser == OP_CLEAR |=> !$rose(m_tvalid), "clear request produced a result")

endmodule

bind per_pixel_scalar_kalman ppsk_check u_check (.*);
